// ===== hdl/spsq_pkg.sv =====
// Shared types, constants and codes for the shape point/segment query block.
// No dependencies; imported by the query interface and every module.
package spsq_pkg;

	localparam int COORD_W      = 12;
	localparam int DIFF_W       = COORD_W + 1;
	localparam int PROD_W       = 2 * DIFF_W;
	localparam int SUM_W        = PROD_W + 1;
	localparam int AC_W         = PROD_W;
	localparam int RAD_W        = 12;
	localparam int R2_W         = 2 * RAD_W;
	localparam int WIDE_W       = 2 * AC_W;
	localparam int MAX_VERTICES = 16;
	localparam int VIDX_W       = $clog2(MAX_VERTICES);
	localparam int VCNT_W       = VIDX_W + 1;
	localparam int KIND_W       = 3;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 12;

	// shape kinds
	localparam logic [KIND_W-1:0] KIND_POINT   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_SEGMENT = 3'd1;
	localparam logic [KIND_W-1:0] KIND_RAY     = 3'd2;
	localparam logic [KIND_W-1:0] KIND_LINE    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_POLYGON = 3'd4;
	localparam logic [KIND_W-1:0] KIND_CIRCLE  = 3'd5;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SHAPE_KIND   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_X      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_Y      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_X     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_Y     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 3'd6;

	// operations
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// product lanes: each is a cross or a dot product of two difference vectors
	localparam int Q_O1  = 0;  // crs(dP, Q1-P1)
	localparam int Q_O2  = 1;  // crs(dP, Q2-P1)
	localparam int Q_O3  = 2;  // crs(dQ, P1-Q1)
	localparam int Q_O4  = 3;  // crs(dQ, P2-Q1)
	localparam int Q_DEN = 4;  // crs(dQ, dP)
	localparam int Q_DA  = 5;
	localparam int Q_DB  = 6;
	localparam int Q_DC  = 7;
	localparam int Q_DD  = 8;
	localparam int Q_RD1 = 9;
	localparam int Q_RD2 = 10;
	localparam int Q_SQ1 = 11;
	localparam int Q_SQ2 = 12;
	localparam int Q_EE  = 13;
	localparam int Q_T   = 14;
	localparam int NQ    = 15;
	localparam logic [NQ-1:0] Q_IS_CROSS = 15'b000_0000_0001_1111;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} pt_t;

	typedef struct packed {
		diff_t x;
		diff_t y;
	} dv_t;

	typedef struct packed {
		logic              cap;
		logic              wr;
		logic              issue;
		logic              rd_en;
		logic              rd_edge;
		logic [VIDX_W-1:0] rd_addr;
		logic              out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic              is_poly;
		logic [VCNT_W-1:0] poly_n;
	} dp_sts_t;

	function automatic dv_t pt_sub(pt_t a, pt_t b);
		dv_t r;
		r.x = DIFF_W'(a.x) - DIFF_W'(b.x);
		r.y = DIFF_W'(a.y) - DIFF_W'(b.y);
		return r;
	endfunction

endpackage

// ===== hdl/spsq_ifs.sv =====
// Valid/ready channel interfaces for query items and result items.
// Depends on spsq_pkg.
interface spsq_query_if import spsq_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              operation;
	logic [VIDX_W-1:0] vertex_index;
	coord_t            vertex_x;
	coord_t            vertex_y;
	coord_t            a_x;
	coord_t            a_y;
	coord_t            b_x;
	coord_t            b_y;

	modport source(output valid, operation, vertex_index, vertex_x, vertex_y,
		a_x, a_y, b_x, b_y, input ready);
	modport sink(input valid, operation, vertex_index, vertex_x, vertex_y,
		a_x, a_y, b_x, b_y, output ready);
endinterface

interface spsq_result_if;
	logic valid;
	logic ready;
	logic contains_a;
	logic crosses_ab;
	logic load_done;

	modport source(output valid, contains_a, crosses_ab, load_done, input ready);
	modport sink(input valid, contains_a, crosses_ab, load_done, output ready);
endinterface

// ===== hdl/spsq_datapath.sv =====
// Datapath: configuration registers, vertex store, product lanes and result logic.
// Depends on spsq_pkg; driven by spsq_ctrl through dp_cmd_t.
module spsq_datapath import spsq_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  operation,
	input  logic [VIDX_W-1:0]     vertex_index,
	input  coord_t                vertex_x,
	input  coord_t                vertex_y,
	input  coord_t                a_x,
	input  coord_t                a_y,
	input  coord_t                b_x,
	input  coord_t                b_y,
	input  dp_cmd_t               cmd,
	output dp_sts_t               sts,
	output logic                  contains_a,
	output logic                  crosses_ab,
	output logic                  load_done
);

	logic [KIND_W-1:0] kind_q;
	pt_t               first_q, second_q;
	logic [RAD_W-1:0]  radius_q;
	logic [VCNT_W-1:0] vcount_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= KIND_POINT;
			first_q  <= '0;
			second_q <= '0;
			radius_q <= '0;
			vcount_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SHAPE_KIND:   kind_q     <= cfg_data[KIND_W-1:0];
				REG_FIRST_X:      first_q.x  <= cfg_data[COORD_W-1:0];
				REG_FIRST_Y:      first_q.y  <= cfg_data[COORD_W-1:0];
				REG_SECOND_X:     second_q.x <= cfg_data[COORD_W-1:0];
				REG_SECOND_Y:     second_q.y <= cfg_data[COORD_W-1:0];
				REG_RADIUS:       radius_q   <= cfg_data[RAD_W-1:0];
				REG_VERTEX_COUNT: vcount_q   <= cfg_data[VCNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign sts.is_poly = (kind_q == KIND_POLYGON);
	assign sts.poly_n  = (vcount_q > VCNT_W'(MAX_VERTICES)) ? VCNT_W'(MAX_VERTICES) : vcount_q;

	// captured item
	logic op_q;
	pt_t  a_q, b_q;

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			op_q  <= operation;
			a_q.x <= a_x;
			a_q.y <= a_y;
			b_q.x <= b_x;
			b_q.y <= b_y;
		end
	end

	// vertex store
	pt_t mem [MAX_VERTICES];
	pt_t vcur_q, vprev_q;

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[vertex_index] <= '{x: vertex_x, y: vertex_y};
		end
		if (cmd.rd_en) begin
			vcur_q  <= mem[cmd.rd_addr];
			vprev_q <= vcur_q;
		end
	end

	logic edge_iss_q, v_s1, v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_iss_q <= 1'b0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
		end else begin
			edge_iss_q <= cmd.rd_en & cmd.rd_edge;
			v_s1       <= edge_iss_q | cmd.issue;
			v_s2       <= v_s1;
		end
	end

	// operand selection
	logic point_like;
	pt_t  p1, p2, q1, q2;
	dv_t  d_p, d_q, u1, u2, w1, w2, y2, z2;
	dv_t  va [NQ];
	dv_t  vb [NQ];

	always_comb begin
		point_like = (kind_q == KIND_POINT) ||
			(((kind_q == KIND_RAY) || (kind_q == KIND_LINE)) && (first_q == second_q));
		if (point_like) begin
			p1 = a_q;     p2 = b_q;     q1 = first_q; q2 = first_q;
		end else if (kind_q == KIND_CIRCLE) begin
			p1 = first_q; p2 = first_q; q1 = a_q;     q2 = b_q;
		end else if (kind_q == KIND_POLYGON) begin
			p1 = a_q;     p2 = b_q;     q1 = vprev_q; q2 = vcur_q;
		end else begin
			p1 = first_q; p2 = second_q; q1 = a_q;    q2 = b_q;
		end
		d_p = pt_sub(p2, p1);
		d_q = pt_sub(q2, q1);
		u1  = pt_sub(q1, p1);
		u2  = pt_sub(q2, p1);
		w1  = pt_sub(p1, q1);
		w2  = pt_sub(p2, q1);
		y2  = pt_sub(p2, q2);
		z2  = pt_sub(q2, p2);
		va[Q_O1]  = d_p; vb[Q_O1]  = u1;
		va[Q_O2]  = d_p; vb[Q_O2]  = u2;
		va[Q_O3]  = d_q; vb[Q_O3]  = w1;
		va[Q_O4]  = d_q; vb[Q_O4]  = w2;
		va[Q_DEN] = d_q; vb[Q_DEN] = d_p;
		va[Q_DA]  = u1;  vb[Q_DA]  = w2;
		va[Q_DB]  = u2;  vb[Q_DB]  = y2;
		va[Q_DC]  = w1;  vb[Q_DC]  = u2;
		va[Q_DD]  = w2;  vb[Q_DD]  = z2;
		va[Q_RD1] = d_p; vb[Q_RD1] = u1;
		va[Q_RD2] = d_p; vb[Q_RD2] = u2;
		va[Q_SQ1] = u1;  vb[Q_SQ1] = u1;
		va[Q_SQ2] = u2;  vb[Q_SQ2] = u2;
		va[Q_EE]  = d_q; vb[Q_EE]  = d_q;
		va[Q_T]   = w1;  vb[Q_T]   = d_q;
	end

	// stage 1: products
	logic signed [PROD_W-1:0] pa_s1 [NQ];
	logic signed [PROD_W-1:0] pb_s1 [NQ];
	logic                     ylt1_s1, ylt2_s1, dyp_s1;
	logic [R2_W-1:0]          r2_s1;

	always_ff @(posedge clk) begin
		for (int k = 0; k < NQ; k++) begin
			pa_s1[k] <= PROD_W'(va[k].x) * PROD_W'(Q_IS_CROSS[k] ? vb[k].y : vb[k].x);
			pb_s1[k] <= PROD_W'(va[k].y) * PROD_W'(Q_IS_CROSS[k] ? vb[k].x : vb[k].y);
		end
		ylt1_s1 <= (u1.y > 0);
		ylt2_s1 <= (u2.y > 0);
		dyp_s1  <= (d_q.y > 0);
		r2_s1   <= R2_W'(radius_q) * R2_W'(radius_q);
	end

	// stage 2: sums and predicates
	logic signed [SUM_W-1:0] qv [NQ];
	logic signed [SUM_W-1:0] r2s;
	logic onq1, onq2, onp1, onp2, hits1, hits2, seg_hit;
	logic ray_ca, ray_cb, both_in;
	logic pl_ca, pl_cb, c_early, c_val;

	always_comb begin
		for (int k = 0; k < NQ; k++) begin
			qv[k] = Q_IS_CROSS[k] ? (SUM_W'(pa_s1[k]) - SUM_W'(pb_s1[k]))
				: (SUM_W'(pa_s1[k]) + SUM_W'(pb_s1[k]));
		end
		r2s   = signed'(SUM_W'(r2_s1));
		onq1  = (qv[Q_O1] == 0) && (qv[Q_DA] >= 0);
		onq2  = (qv[Q_O2] == 0) && (qv[Q_DB] >= 0);
		onp1  = (qv[Q_O3] == 0) && (qv[Q_DC] >= 0);
		onp2  = (qv[Q_O4] == 0) && (qv[Q_DD] >= 0);
		hits1 = (qv[Q_O1] > 0 && qv[Q_O2] < 0) || (qv[Q_O1] < 0 && qv[Q_O2] > 0) ||
			qv[Q_O1] == 0 || qv[Q_O2] == 0;
		hits2 = (qv[Q_O3] > 0 && qv[Q_O4] < 0) || (qv[Q_O3] < 0 && qv[Q_O4] > 0) ||
			qv[Q_O3] == 0 || qv[Q_O4] == 0;
		seg_hit = !(qv[Q_DEN] == 0 && !(onq1 || onq2 || onp1 || onp2)) && hits1 && hits2;

		// ray: origin P1, direction dP, query segment Q1-Q2
		ray_ca = (qv[Q_O1] == 0) && (qv[Q_RD1] >= 0);
		if (qv[Q_EE] == 0) begin
			ray_cb = ray_ca;
		end else if (qv[Q_DEN] == 0) begin
			ray_cb = (qv[Q_O1] == 0) &&
				((qv[Q_RD1] >= 0) || ((qv[Q_O2] == 0) && (qv[Q_RD2] >= 0)));
		end else if (qv[Q_DEN] > 0) begin
			ray_cb = (qv[Q_O3] <= 0) && (qv[Q_O1] >= 0) && (qv[Q_O1] <= qv[Q_DEN]);
		end else begin
			ray_cb = (qv[Q_O3] >= 0) && (qv[Q_O1] <= 0) && (qv[Q_O1] >= qv[Q_DEN]);
		end

		if (point_like) begin
			pl_ca = (qv[Q_SQ1] == 0);
			pl_cb = onq1;
		end else begin
			case (kind_q)
				KIND_SEGMENT: begin
					pl_ca = onq1;
					pl_cb = seg_hit;
				end
				KIND_RAY: begin
					pl_ca = ray_ca;
					pl_cb = ray_cb;
				end
				KIND_LINE: begin
					pl_ca = (qv[Q_O1] == 0);
					pl_cb = hits1;
				end
				default: begin
					pl_ca = 1'b0;
					pl_cb = 1'b0;
				end
			endcase
		end

		// circle: centre P1, segment Q1-Q2
		both_in = (qv[Q_SQ1] < r2s) && (qv[Q_SQ2] < r2s);
		c_early = 1'b1;
		if (both_in) begin
			c_val = 1'b0;
		end else if (qv[Q_EE] == 0 || qv[Q_T] <= 0) begin
			c_val = (qv[Q_SQ1] <= r2s);
		end else if (qv[Q_T] >= qv[Q_EE]) begin
			c_val = (qv[Q_SQ2] <= r2s);
		end else begin
			c_val   = 1'b0;
			c_early = 1'b0;
		end
	end

	logic            on_ca_s2, seg_s2, same_s2, tog_s2, pl_ca_s2, pl_cb_s2;
	logic            c_early_s2, c_val_s2;
	logic [AC_W-1:0] ac_s2, ee_s2;

	always_ff @(posedge clk) begin
		if (v_s1) begin
			seg_s2     <= seg_hit;
			same_s2    <= (qv[Q_SQ1] == 0) || (qv[Q_SQ2] == 0);
			tog_s2     <= (ylt1_s1 != ylt2_s1) && (dyp_s1 ? (qv[Q_O3] > 0) : (qv[Q_O3] < 0));
			pl_ca_s2   <= pl_ca;
			pl_cb_s2   <= pl_cb;
			on_ca_s2   <= (qv[Q_SQ1] <= r2s);
			c_early_s2 <= c_early;
			c_val_s2   <= c_val;
			ac_s2      <= (qv[Q_O3] < 0) ? AC_W'(-qv[Q_O3]) : AC_W'(qv[Q_O3]);
			ee_s2      <= AC_W'(qv[Q_EE]);
		end
	end

	// stage 3: distance products for the circle, polygon accumulation
	logic [WIDE_W-1:0] lhs_s3, rhs_s3;
	logic              psame_q, podd_q, phit_q;

	always_ff @(posedge clk) begin
		if (v_s2) begin
			lhs_s3 <= WIDE_W'(ac_s2) * WIDE_W'(ac_s2);
			rhs_s3 <= WIDE_W'(r2_s1) * WIDE_W'(ee_s2);
		end
		if (cmd.cap) begin
			psame_q <= 1'b0;
			podd_q  <= 1'b0;
			phit_q  <= 1'b0;
		end else if (v_s2) begin
			psame_q <= psame_q | same_s2;
			podd_q  <= podd_q ^ tog_s2;
			phit_q  <= phit_q | seg_s2;
		end
	end

	logic res_ca, res_cb;

	always_comb begin
		if (op_q == OP_LOAD) begin
			res_ca = 1'b0;
			res_cb = 1'b0;
		end else begin
			case (kind_q)
				KIND_POLYGON: begin
					res_ca = psame_q | podd_q;
					res_cb = phit_q;
				end
				KIND_CIRCLE: begin
					res_ca = on_ca_s2;
					res_cb = c_early_s2 ? c_val_s2 : (lhs_s3 <= rhs_s3);
				end
				default: begin
					res_ca = pl_ca_s2;
					res_cb = pl_cb_s2;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			contains_a <= res_ca;
			crosses_ab <= res_cb;
			load_done  <= (op_q == OP_LOAD);
		end
	end

endmodule

// ===== hdl/spsq_ctrl.sv =====
// Controller: item handshake, polygon edge walk, pipeline drain and result valid.
// Depends on spsq_pkg; commands spsq_datapath.
module spsq_ctrl import spsq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    operation,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ISSUE = 3'd1;
	localparam logic [2:0] S_POLY  = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	localparam logic [1:0] DRAIN_PLAIN = 2'd1;
	localparam logic [1:0] DRAIN_POLY  = 2'd2;

	logic [2:0]        state_q;
	logic [VCNT_W-1:0] cnt_q;
	logic [1:0]        drain_q;
	logic              accept, out_free;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid & in_ready;
	assign out_free = !out_valid || out_ready;

	always_comb begin
		cmd          = '0;
		cmd.cap      = accept;
		cmd.wr       = accept && (operation == OP_LOAD);
		cmd.issue    = (state_q == S_ISSUE);
		cmd.rd_en    = (state_q == S_POLY);
		cmd.rd_edge  = (cnt_q != '0);
		cmd.rd_addr  = (cnt_q == sts.poly_n) ? '0 : cnt_q[VIDX_W-1:0];
		cmd.out_load = (state_q == S_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			drain_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						if (operation == OP_LOAD) begin
							state_q <= S_DONE;
						end else if (sts.is_poly) begin
							state_q <= (sts.poly_n < VCNT_W'(3)) ? S_DONE : S_POLY;
						end else begin
							state_q <= S_ISSUE;
						end
					end
				end
				S_ISSUE: begin
					drain_q <= DRAIN_PLAIN;
					state_q <= S_DRAIN;
				end
				S_POLY: begin
					if (cnt_q == sts.poly_n) begin
						drain_q <= DRAIN_POLY;
						state_q <= S_DRAIN;
					end else begin
						cnt_q <= cnt_q + VCNT_W'(1);
					end
				end
				S_DRAIN: begin
					if (drain_q == '0) begin
						state_q <= S_DONE;
					end else begin
						drain_q <= drain_q - 2'd1;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/shape_point_segment_query.sv =====
// Sequence: a vertex load, or a polygon query with fewer than three vertices, goes from
// acceptance straight to the done state; a point, segment, ray, line or circle query first
// passes the issue and drain states; a polygon query of n vertices (n saturated at
// MAX_VERTICES) first walks its edges, reading one vertex a cycle from the store, then drains.
// Throughput: one item at a time; the next is taken once the result sits in the output register.
// Reset: asynchronous, active low; clears control and configuration, not the store.
module shape_point_segment_query import spsq_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	spsq_query_if.sink            query,
	spsq_result_if.source         result
);

	// Controller and datapath meet only through these two structs.
	dp_cmd_t cmd;
	dp_sts_t sts;

	// The controller owns the handshakes: the query side is ready whenever no
	// item is in flight, even if a result is still waiting in the output register.
	spsq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (query.valid),
		.operation (query.operation),
		.in_ready  (query.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds configuration, the vertex store, fifteen product lanes
	// (cross and dot products of difference vectors) and the result register.
	// Every shape maps onto the same lanes through its choice of points P1, P2,
	// Q1 and Q2; a polygon streams one edge per cycle through them.
	spsq_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.operation    (query.operation),
		.vertex_index (query.vertex_index),
		.vertex_x     (query.vertex_x),
		.vertex_y     (query.vertex_y),
		.a_x          (query.a_x),
		.a_y          (query.a_y),
		.b_x          (query.b_x),
		.b_y          (query.b_y),
		.cmd          (cmd),
		.sts          (sts),
		.contains_a   (result.contains_a),
		.crosses_ab   (result.crosses_ab),
		.load_done    (result.load_done)
	);

endmodule

// ===== sim/shape_point_segment_query_tb.sv =====
// Self-checking testbench for the shape point/segment query block.
// Depends on spsq_pkg, spsq_ifs and shape_point_segment_query from hdl.
module shape_point_segment_query_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import spsq_pkg::*;

	// one query-channel transaction and the answer it should give
	typedef struct {
		logic              op;
		logic [VIDX_W-1:0] idx;
		coord_t            vx, vy, ax, ay, bx, by;
	} txn_t;

	typedef struct {
		logic contains_a;
		logic crosses_ab;
		logic load_done;
	} answer_t;

	typedef struct {
		longint x;
		longint y;
	} vec_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	spsq_query_if  query();
	spsq_result_if result();

	shape_point_segment_query dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.query    (query.sink),
		.result   (result.source)
	);

	always #6 clk = ~clk;

	// Shadow copy of the shape registers and the vertex store
	logic [KIND_W-1:0] shp_kind;
	vec_t              shp_first, shp_second;
	longint            shp_radius;
	int                shp_count;
	vec_t              vstore[MAX_VERTICES];

	txn_t    pending_txns[$];   // waiting to be offered
	answer_t awaited[$];        // predicted, not yet seen on the result channel
	txn_t    cur_txn;
	bit      calm = 1'b0;       // no idling on either side while set
	int      failures = 0;
	int      results_seen = 0;

	// ---------------------------------------------------------------------
	// Exact integer geometry
	// ---------------------------------------------------------------------
	function automatic vec_t vsub(vec_t a, vec_t b);
		vec_t r;
		r.x = a.x - b.x;
		r.y = a.y - b.y;
		return r;
	endfunction

	function automatic longint vcross(vec_t a, vec_t b);
		return a.x * b.y - a.y * b.x;
	endfunction

	function automatic longint vdot(vec_t a, vec_t b);
		return a.x * b.x + a.y * b.y;
	endfunction

	function automatic bit vsame(vec_t a, vec_t b);
		return a.x == b.x && a.y == b.y;
	endfunction

	function automatic longint sqlen(vec_t v);
		return v.x * v.x + v.y * v.y;
	endfunction

	function automatic bit on_seg(vec_t a, vec_t b, vec_t p);
		vec_t u, v;
		u = vsub(p, a);
		v = vsub(b, p);
		return vcross(u, v) == 0 && vdot(u, v) >= 0;
	endfunction

	// segment s1-s2 touches the infinite line through a, b
	function automatic bit line_hits(vec_t a, vec_t b, vec_t s1, vec_t s2);
		vec_t   d;
		longint c1, c2;
		d  = vsub(b, a);
		c1 = vcross(d, vsub(s1, a));
		c2 = vcross(d, vsub(s2, a));
		return (c1 > 0 && c2 < 0) || (c1 < 0 && c2 > 0) || c1 == 0 || c2 == 0;
	endfunction

	function automatic bit seg_meet(vec_t p1, vec_t p2, vec_t q1, vec_t q2);
		if (vcross(vsub(q2, q1), vsub(p2, p1)) == 0 &&
				!(on_seg(p1, p2, q1) || on_seg(p1, p2, q2) ||
				  on_seg(q1, q2, p1) || on_seg(q1, q2, p2)))
			return 1'b0;
		return line_hits(p1, p2, q1, q2) && line_hits(q1, q2, p1, p2);
	endfunction

	function automatic bit ray_has(vec_t o, vec_t d, vec_t p);
		vec_t w;
		w = vsub(p, o);
		return vcross(d, w) == 0 && vdot(d, w) >= 0;
	endfunction

	function automatic bit ray_meet(vec_t o, vec_t d, vec_t a, vec_t b);
		vec_t   e, w;
		longint den, tn, un;
		e = vsub(b, a);
		w = vsub(a, o);
		if (e.x == 0 && e.y == 0)
			return ray_has(o, d, a);
		den = vcross(d, e);
		if (den == 0) begin
			if (vcross(d, w) != 0)
				return 1'b0;
			return ray_has(o, d, a) || ray_has(o, d, b);
		end
		tn = vcross(w, e);
		un = vcross(w, d);
		if (den < 0) begin
			den = -den;
			tn  = -tn;
			un  = -un;
		end
		return tn >= 0 && un >= 0 && un <= den;
	endfunction

	// distance from the centre to segment AB against the radius
	function automatic bit circle_meet(vec_t c, vec_t a, vec_t b);
		longint r2, ee, t;
		vec_t   e, w;
		r2 = shp_radius * shp_radius;
		e  = vsub(b, a);
		w  = vsub(c, a);
		ee = sqlen(e);
		if (sqlen(w) < r2 && sqlen(vsub(c, b)) < r2)
			return 1'b0;
		if (ee == 0)
			return sqlen(w) <= r2;
		t = vdot(w, e);
		if (t <= 0)
			return sqlen(w) <= r2;
		if (t >= ee)
			return sqlen(vsub(c, b)) <= r2;
		t = vcross(e, w);
		if (t < 0)
			t = -t;
		return t * t <= r2 * ee;
	endfunction

	function automatic int poly_size();
		return shp_count > MAX_VERTICES ? MAX_VERTICES : shp_count;
	endfunction

	// even-odd horizontal crossing, vertices count as inside
	function automatic bit poly_has(vec_t p);
		int     n;
		bit     odd;
		vec_t   v1, v2;
		longint dy, lhs, rhs;
		n   = poly_size();
		odd = 1'b0;
		if (n < 3)
			return 1'b0;
		for (int i = 0; i < n; i++) begin
			v1 = vstore[i];
			v2 = vstore[(i + 1) % n];
			if (vsame(p, v1) || vsame(p, v2))
				return 1'b1;
			if ((p.y < v1.y) == (p.y < v2.y))
				continue;
			dy  = v2.y - v1.y;
			lhs = (p.x - v1.x) * dy;
			rhs = (p.y - v1.y) * (v2.x - v1.x);
			if (dy > 0 ? lhs < rhs : lhs > rhs)
				odd = ~odd;
		end
		return odd;
	endfunction

	function automatic bit poly_meet(vec_t a, vec_t b);
		int n;
		n = poly_size();
		if (n < 3)
			return 1'b0;
		for (int i = 0; i < n; i++)
			if (seg_meet(a, b, vstore[i], vstore[(i + 1) % n]))
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic vec_t mkvec(coord_t x, coord_t y);
		vec_t r;
		r.x = longint'(x);
		r.y = longint'(y);
		return r;
	endfunction

	// Works out the answer for one accepted transaction; loads update the store
	function automatic answer_t shape_answer(txn_t t);
		answer_t r;
		vec_t    a, b, d;
		bit      degen;
		r = '{1'b0, 1'b0, 1'b0};
		if (t.op == OP_LOAD) begin
			vstore[t.idx] = mkvec(t.vx, t.vy);
			r.load_done = 1'b1;
			return r;
		end
		a     = mkvec(t.ax, t.ay);
		b     = mkvec(t.bx, t.by);
		d     = vsub(shp_second, shp_first);
		degen = d.x == 0 && d.y == 0;
		case (shp_kind)
			KIND_POINT: begin
				r.contains_a = vsame(a, shp_first);
				r.crosses_ab = on_seg(a, b, shp_first);
			end
			KIND_SEGMENT: begin
				r.contains_a = on_seg(shp_first, shp_second, a);
				r.crosses_ab = seg_meet(shp_first, shp_second, a, b);
			end
			KIND_RAY, KIND_LINE: begin
				if (degen) begin
					r.contains_a = vsame(a, shp_first);
					r.crosses_ab = on_seg(a, b, shp_first);
				end else if (shp_kind == KIND_RAY) begin
					r.contains_a = ray_has(shp_first, d, a);
					r.crosses_ab = ray_meet(shp_first, d, a, b);
				end else begin
					r.contains_a = vcross(vsub(a, shp_first), d) == 0;
					r.crosses_ab = line_hits(shp_first, shp_second, a, b);
				end
			end
			KIND_POLYGON: begin
				r.contains_a = poly_has(a);
				r.crosses_ab = poly_meet(a, b);
			end
			KIND_CIRCLE: begin
				r.contains_a = sqlen(vsub(a, shp_first)) <= shp_radius * shp_radius;
				r.crosses_ab = circle_meet(shp_first, a, b);
			end
			default: ;  // unknown kinds answer false
		endcase
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Driver: offers queued transactions, idles at random
	// ---------------------------------------------------------------------
	initial begin
		query.valid        = 1'b0;
		query.operation    = OP_QUERY;
		query.vertex_index = '0;
		query.vertex_x     = '0;
		query.vertex_y     = '0;
		query.a_x          = '0;
		query.a_y          = '0;
		query.b_x          = '0;
		query.b_y          = '0;
		result.ready       = 1'b0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query.valid <= 1'b0;
		end else begin
			// prediction is made at acceptance, so loads and queries stay in order
			if (query.valid && query.ready)
				awaited.push_back(shape_answer(cur_txn));
			if (!query.valid || query.ready) begin
				if (pending_txns.size() != 0 && (calm || $urandom_range(99) >= 34)) begin
					cur_txn             = pending_txns.pop_front();
					query.valid        <= 1'b1;
					query.operation    <= cur_txn.op;
					query.vertex_index <= cur_txn.idx;
					query.vertex_x     <= cur_txn.vx;
					query.vertex_y     <= cur_txn.vy;
					query.a_x          <= cur_txn.ax;
					query.a_y          <= cur_txn.ay;
					query.b_x          <= cur_txn.bx;
					query.b_y          <= cur_txn.by;
				end else begin
					query.valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: checks each result transaction, stalls at random, and once
	// holds ready low for a long stretch so the block backs up its input
	// ---------------------------------------------------------------------
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	answer_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else begin
			if (result.valid && result.ready) begin
				results_seen++;
				if (awaited.size() == 0) begin
					failures++;
					$display("%0t: result with nothing expected: contains_a %b crosses_ab %b load_done %b",
						$time, result.contains_a, result.crosses_ab, result.load_done);
				end else begin
					want = awaited.pop_front();
					if (result.contains_a !== want.contains_a) begin
						failures++;
						$display("%0t: contains_a expected %b actual %b", $time,
							want.contains_a, result.contains_a);
					end
					if (result.crosses_ab !== want.crosses_ab) begin
						failures++;
						$display("%0t: crosses_ab expected %b actual %b", $time,
							want.crosses_ab, result.crosses_ab);
					end
					if (result.load_done !== want.load_done) begin
						failures++;
						$display("%0t: load_done expected %b actual %b", $time,
							want.load_done, result.load_done);
					end
				end
			end
			if (!hold_done && results_seen == 150) begin
				hold_done = 1'b1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				result.ready <= 1'b0;
			end else begin
				result.ready <= calm || $urandom_range(99) >= 34;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------
	function automatic coord_t clamp_c(longint v);
		if (v > 2047)
			return coord_t'(2047);
		if (v < -2048)
			return coord_t'(-2048);
		return coord_t'(v);
	endfunction

	// mix of full-range, small, extreme and near-the-shape coordinates
	function automatic coord_t pick_coord(longint hint1, longint hint2);
		case ($urandom_range(5))
			0:       return coord_t'($urandom);
			1:       return clamp_c($signed($urandom_range(16)) - 8);
			2:       return $urandom_range(1) ? coord_t'(2047) : coord_t'(-2048);
			3:       return clamp_c(hint1 + $signed($urandom_range(4)) - 2);
			4:       return clamp_c(hint2 + $signed($urandom_range(4)) - 2);
			default: return clamp_c(hint1 + $signed($urandom_range(400)) - 200);
		endcase
	endfunction

	function automatic txn_t mk_query(coord_t ax, coord_t ay, coord_t bx, coord_t by);
		txn_t t;
		t = '{OP_QUERY, VIDX_W'($urandom), coord_t'($urandom), coord_t'($urandom),
			ax, ay, bx, by};
		return t;
	endfunction

	function automatic txn_t mk_load(int slot, coord_t x, coord_t y);
		txn_t t;
		t = '{OP_LOAD, VIDX_W'(slot), x, y, coord_t'($urandom), coord_t'($urandom),
			coord_t'($urandom), coord_t'($urandom)};
		return t;
	endfunction

	// random query steered toward the shape (or a stored vertex for polygons)
	function automatic txn_t rand_query();
		longint h1x, h1y, h2x, h2y;
		coord_t ax, ay, bx, by;
		int     k;
		h1x = shp_first.x;
		h1y = shp_first.y;
		h2x = shp_second.x;
		h2y = shp_second.y;
		if (shp_kind == KIND_POLYGON) begin
			k   = $urandom_range(MAX_VERTICES - 1);
			h1x = vstore[k].x;
			h1y = vstore[k].y;
			k   = $urandom_range(MAX_VERTICES - 1);
			h2x = vstore[k].x;
			h2y = vstore[k].y;
		end
		if (shp_kind == KIND_CIRCLE) begin
			h2x = shp_first.x + shp_radius;
			h2y = shp_first.y;
		end
		ax = pick_coord(h1x, h2x);
		ay = pick_coord(h1y, h2y);
		if ($urandom_range(7) == 0) begin
			bx = ax;  // degenerate query segment
			by = ay;
		end else begin
			bx = pick_coord(h2x, h1x);
			by = pick_coord(h2y, h1y);
		end
		return mk_query(ax, ay, bx, by);
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_we    <= 1'b1;
		@(posedge clk);
	endtask

	// Writes every register and the shadow copy; only called with the block idle
	task automatic set_shape(logic [KIND_W-1:0] kind, coord_t fx, coord_t fy,
			coord_t sx, coord_t sy, logic [RAD_W-1:0] rad, int cnt);
		write_reg(REG_SHAPE_KIND, CFG_DATA_W'(kind));
		write_reg(REG_FIRST_X, fx);
		write_reg(REG_FIRST_Y, fy);
		write_reg(REG_SECOND_X, sx);
		write_reg(REG_SECOND_Y, sy);
		write_reg(REG_RADIUS, rad);
		write_reg(REG_VERTEX_COUNT, CFG_DATA_W'(cnt));
		cfg_we     <= 1'b0;
		shp_kind   = kind;
		shp_first  = mkvec(fx, fy);
		shp_second = mkvec(sx, sy);
		shp_radius = longint'(rad);
		shp_count  = cnt & 31;
	endtask

	task automatic drain();
		while (pending_txns.size() != 0 || query.valid || awaited.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);  // longest polygon walk plus margin
	endtask

	// directed corner cases common to every shape, then random queries
	task automatic run_phase(int nrand);
		coord_t fx, fy, sx, sy;
		fx = coord_t'(shp_first.x);
		fy = coord_t'(shp_first.y);
		sx = coord_t'(shp_second.x);
		sy = coord_t'(shp_second.y);
		pending_txns.push_back(mk_query(fx, fy, fx, fy));
		pending_txns.push_back(mk_query(sx, sy, fx, fy));
		pending_txns.push_back(mk_query(-12'sd2048, -12'sd2048, 12'sd2047, 12'sd2047));
		pending_txns.push_back(mk_query(12'sd2047, -12'sd2048, -12'sd2048, 12'sd2047));
		pending_txns.push_back(mk_query(12'sd2047, 12'sd2047, 12'sd2047, 12'sd2047));
		pending_txns.push_back(mk_query(clamp_c(fx + 1), fy, clamp_c(fx - 1), fy));
		for (int i = 0; i < nrand; i++)
			pending_txns.push_back(rand_query());
		drain();
	endtask

	// ---------------------------------------------------------------------
	// Test sequence
	// ---------------------------------------------------------------------
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// point, including the corner of the coordinate range
		set_shape(KIND_POINT, 12'sd5, -12'sd3, 12'sd0, 12'sd0, 12'd0, 0);
		run_phase(50);
		set_shape(KIND_POINT, -12'sd2048, 12'sd2047, 12'sd0, 12'sd0, 12'd0, 0);
		run_phase(20);

		// segments, one over the whole range; the first phase runs without idling
		calm = 1'b1;
		set_shape(KIND_SEGMENT, -12'sd4, -12'sd2, 12'sd6, 12'sd3, 12'd0, 0);
		run_phase(60);
		calm = 1'b0;
		set_shape(KIND_SEGMENT, -12'sd2048, -12'sd2048, 12'sd2047, 12'sd2047, 12'd0, 0);
		run_phase(40);

		// rays and lines, and their degenerate single-point forms
		set_shape(KIND_RAY, 12'sd1, 12'sd1, 12'sd3, 12'sd2, 12'd0, 0);
		run_phase(60);
		set_shape(KIND_RAY, 12'sd7, -12'sd7, 12'sd7, -12'sd7, 12'd0, 0);
		run_phase(25);
		set_shape(KIND_LINE, -12'sd2, 12'sd0, 12'sd2, 12'sd4, 12'd0, 0);
		run_phase(60);
		set_shape(KIND_LINE, 12'sd2047, 12'sd2047, 12'sd2047, 12'sd2047, 12'd0, 0);
		run_phase(25);

		// polygon: fill the whole store, a square in the first four slots
		set_shape(KIND_POLYGON, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'd0, 4);
		pending_txns.push_back(mk_load(0, -12'sd1000, -12'sd1000));
		pending_txns.push_back(mk_load(1, 12'sd1000, -12'sd1000));
		pending_txns.push_back(mk_load(2, 12'sd1000, 12'sd1000));
		pending_txns.push_back(mk_load(3, -12'sd1000, 12'sd1000));
		for (int i = 4; i < MAX_VERTICES; i++)
			pending_txns.push_back(mk_load(i, clamp_c($signed($urandom_range(40)) - 20),
				clamp_c($signed($urandom_range(40)) - 20)));
		pending_txns.push_back(mk_load(MAX_VERTICES - 1, 12'sd2047, -12'sd2048));
		pending_txns.push_back(mk_query(-12'sd1000, 12'sd0, 12'sd0, 12'sd0));
		pending_txns.push_back(mk_query(12'sd1000, 12'sd1000, 12'sd2000, 12'sd2000));
		run_phase(50);

		// count of sixteen and saturating counts, with reloads mixed in
		for (int cnt = 16; cnt <= 31; cnt += 15) begin
			set_shape(KIND_POLYGON, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'd0, cnt);
			for (int i = 0; i < 30; i++)
				pending_txns.push_back(mk_load($urandom_range(MAX_VERTICES - 1),
					pick_coord(0, 0), pick_coord(0, 0)));
			run_phase(60);
		end

		// too few vertices to form a polygon
		set_shape(KIND_POLYGON, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'd0, 2);
		run_phase(15);
		set_shape(KIND_POLYGON, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'd0, 0);
		run_phase(10);

		// circles: zero radius, largest radius, ordinary
		set_shape(KIND_CIRCLE, 12'sd3, 12'sd3, 12'sd0, 12'sd0, 12'd0, 0);
		run_phase(30);
		set_shape(KIND_CIRCLE, -12'sd2048, 12'sd2047, 12'sd0, 12'sd0, 12'd4095, 0);
		run_phase(30);
		set_shape(KIND_CIRCLE, 12'sd10, -12'sd5, 12'sd0, 12'sd0, 12'd9, 0);
		run_phase(70);

		// unknown shape kinds
		set_shape(3'd6, 12'sd0, 12'sd0, 12'sd1, 12'sd1, 12'd5, 4);
		run_phase(10);
		set_shape(3'd7, 12'sd0, 12'sd0, 12'sd1, 12'sd1, 12'd5, 4);
		run_phase(10);

		if (failures == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// safety net against a hung handshake
	initial begin
		#5ms;
		$display("Verification failed");
		$finish;
	end

endmodule
